@@ hdl/gle_pkg.sv @@
// shared constants, types and helper functions of the gray laplacian edge block
// no dependencies; every other file of the block but gle_ram refers to this package by scoped names
`default_nettype none

package gle_pkg;

    // line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int NUM_SLOTS = 3;
    localparam int SLOT_W    = 2;
    localparam int GRAY_W    = 8;
    localparam int WORD_W    = NUM_SLOTS * GRAY_W;

    // counters and configuration fields
    localparam int ROW_W      = 16;
    localparam int FW_W       = 12;
    localparam int FH_W       = 16;
    localparam int THR_W      = 8;
    localparam int EW_W       = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FW_W-1:0]  FW_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0]  FH_RESET  = FH_W'(480);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } cfg_index_t;

    // request opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // luma weights, 16 fractional bits
    localparam int          SUM_W  = 24;
    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;

    // signed laplacian sum, -1020..1020
    localparam int LAP_W = 12;

    // result queue
    localparam int QUEUE_DEPTH = 3;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic              wr_en;
        logic              emit;
        logic              drain;
        logic              use_left;
        logic              last;
        logic [COL_W-1:0]  addr_a;
        logic [SLOT_W-1:0] wr_slot;
        logic [SLOT_W-1:0] ctr_slot;
        logic [SLOT_W-1:0] up_slot;
        logic [GRAY_W-1:0] gray;
    } s1_req_t;

    typedef struct packed {
        logic edge_res;
        logic frame_last;
    } result_t;

    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(NUM_SLOTS - 1) : s - 1'b1;
    endfunction

    function automatic logic [GRAY_W-1:0] slot_byte(input logic [WORD_W-1:0] w,
                                                    input logic [SLOT_W-1:0] s);
        logic [GRAY_W-1:0] b;
        case (s)
            2'd1:    b = w[GRAY_W +: GRAY_W];
            2'd2:    b = w[2*GRAY_W +: GRAY_W];
            default: b = w[0 +: GRAY_W];
        endcase
        return b;
    endfunction

    function automatic logic [WORD_W-1:0] slot_merge(input logic [WORD_W-1:0] w,
                                                     input logic [SLOT_W-1:0] s,
                                                     input logic [GRAY_W-1:0] g);
        logic [WORD_W-1:0] r;
        r = w;
        case (s)
            2'd1:    r[GRAY_W +: GRAY_W]   = g;
            2'd2:    r[2*GRAY_W +: GRAY_W] = g;
            default: r[0 +: GRAY_W]        = g;
        endcase
        return r;
    endfunction

    function automatic logic [GRAY_W-1:0] gray_of(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(r) * SUM_W'(COEF_R) + SUM_W'(g) * SUM_W'(COEF_G)
            + SUM_W'(b) * SUM_W'(COEF_B);
        return sum[SUM_W-1 -: GRAY_W];
    endfunction

endpackage

`default_nettype wire

@@ hdl/gle_ram.sv @@
// generic synchronous ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module gle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

@@ hdl/gle_front.sv @@
// request front end: position counters, gray conversion and line store addressing
// depends on gle_pkg
`default_nettype none

module gle_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic                        op,
    input  wire logic [7:0]                  red,
    input  wire logic [7:0]                  green,
    input  wire logic [7:0]                  blue,
    input  wire logic [gle_pkg::FW_W-1:0]    frame_width,
    input  wire logic [gle_pkg::FH_W-1:0]    frame_height,
    output logic      [gle_pkg::COL_W-1:0]   rd_addr_a,
    output logic      [gle_pkg::COL_W-1:0]   rd_addr_b,
    output gle_pkg::s1_req_t                 req
);

    logic [gle_pkg::COL_W-1:0]  in_col_reg,   in_col_next;
    logic [gle_pkg::ROW_W-1:0]  in_row_reg,   in_row_next;
    logic [gle_pkg::SLOT_W-1:0] in_slot_reg,  in_slot_next;
    logic [gle_pkg::COL_W-1:0]  out_col_reg,  out_col_next;
    logic [gle_pkg::ROW_W-1:0]  out_row_reg,  out_row_next;
    logic [gle_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;

    logic [gle_pkg::EW_W-1:0] eff_w;
    logic [gle_pkg::FH_W-1:0] eff_h;
    logic                     complete;
    logic                     is_pixel;
    logic                     pix_take;
    logic                     drain_take;
    logic                     in_col_last;
    logic                     out_col_last;
    logic                     right_ok;

    // width clamped to 1..max, height 0 taken as 1
    always_comb
    begin
        if (frame_width == '0)
        begin
            eff_w = gle_pkg::EW_W'(1);
        end
        else if (gle_pkg::EW_W'(frame_width) > gle_pkg::EW_W'(gle_pkg::MAX_WIDTH))
        begin
            eff_w = gle_pkg::EW_W'(gle_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_w = gle_pkg::EW_W'(frame_width);
        end
    end

    assign eff_h        = (frame_height == '0) ? gle_pkg::FH_W'(1) : frame_height;
    assign complete     = (in_row_reg >= eff_h);
    assign is_pixel     = (op == gle_pkg::OP_PIXEL);
    assign pix_take     = is_pixel && !complete;
    assign drain_take   = !is_pixel && complete;
    assign in_col_last  = (gle_pkg::EW_W'(in_col_reg) + 1'b1 >= eff_w);
    assign out_col_last = (gle_pkg::EW_W'(out_col_reg) + 1'b1 >= eff_w);
    assign right_ok     = (gle_pkg::EW_W'(out_col_reg) + 1'b1 < eff_w);

    // port a: write column of a pixel (same as the output column once rows lag),
    // port b: right neighbor with the border replicated
    assign rd_addr_a = is_pixel ? in_col_reg : out_col_reg;
    assign rd_addr_b = right_ok ? out_col_reg + 1'b1 : out_col_reg;

    always_comb
    begin
        req.wr_en    = pix_take;
        req.emit     = (pix_take && (in_row_reg != '0)) || drain_take;
        req.drain    = !is_pixel;
        req.use_left = (out_col_reg != '0);
        req.last     = drain_take && out_col_last;
        req.addr_a   = rd_addr_a;
        req.wr_slot  = in_slot_reg;
        req.ctr_slot = out_slot_reg;
        req.up_slot  = (out_row_reg != '0) ? gle_pkg::slot_prev(out_slot_reg) : out_slot_reg;
        req.gray     = gle_pkg::gray_of(red, green, blue);
    end

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        if (accept && pix_take)
        begin
            if (in_row_reg != '0)
            begin
                if (out_col_last)
                begin
                    out_col_next  = '0;
                    out_row_next  = out_row_reg + 1'b1;
                    out_slot_next = gle_pkg::slot_next(out_slot_reg);
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
            if (in_col_last)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + 1'b1;
                in_slot_next = gle_pkg::slot_next(in_slot_reg);
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
        else if (accept && drain_take)
        begin
            if (out_col_last)
            begin
                // frame done, start over
                in_col_next   = '0;
                in_row_next   = '0;
                in_slot_next  = '0;
                out_col_next  = '0;
                out_row_next  = '0;
                out_slot_next = '0;
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gle_stencil.sv @@
// read-modify-write stage: forwards the last write, merges the new gray byte
// and evaluates the cross laplacian and threshold; depends on gle_pkg
`default_nettype none

module gle_stencil (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire gle_pkg::s1_req_t            req,
    input  wire logic [gle_pkg::COL_W-1:0]   rd_addr_b,
    input  wire logic [gle_pkg::WORD_W-1:0]  ram_a,
    input  wire logic [gle_pkg::WORD_W-1:0]  ram_b,
    input  wire logic [gle_pkg::THR_W-1:0]   edge_threshold,
    output logic                             wr_en,
    output logic      [gle_pkg::COL_W-1:0]   wr_addr,
    output logic      [gle_pkg::WORD_W-1:0]  wr_data,
    output logic                             s1_valid,
    output logic                             push,
    output gle_pkg::result_t                 push_data
);

    logic                          s1_valid_reg;
    gle_pkg::s1_req_t              s1_req_reg;
    logic [gle_pkg::COL_W-1:0]     s1_addr_b_reg;
    logic                          fwd_en_reg;
    logic [gle_pkg::COL_W-1:0]     fwd_addr_reg;
    logic [gle_pkg::WORD_W-1:0]    fwd_word_reg;
    logic [gle_pkg::GRAY_W-1:0]    left_reg;

    logic [gle_pkg::WORD_W-1:0] word_a;
    logic [gle_pkg::WORD_W-1:0] word_b;
    logic [gle_pkg::GRAY_W-1:0] centre;
    logic [gle_pkg::GRAY_W-1:0] up;
    logic [gle_pkg::GRAY_W-1:0] down;
    logic [gle_pkg::GRAY_W-1:0] left;
    logic [gle_pkg::GRAY_W-1:0] right;
    logic [gle_pkg::LAP_W-1:0]  lap;
    logic [gle_pkg::GRAY_W-1:0] level;

    // ram reads old data when read and write hit one entry at the same edge
    assign word_a = (fwd_en_reg && (fwd_addr_reg == s1_req_reg.addr_a)) ? fwd_word_reg : ram_a;
    assign word_b = (fwd_en_reg && (fwd_addr_reg == s1_addr_b_reg)) ? fwd_word_reg : ram_b;

    assign centre = gle_pkg::slot_byte(word_a, s1_req_reg.ctr_slot);
    assign up     = gle_pkg::slot_byte(word_a, s1_req_reg.up_slot);
    assign right  = gle_pkg::slot_byte(word_b, s1_req_reg.ctr_slot);
    assign left   = s1_req_reg.use_left ? left_reg : centre;
    assign down   = s1_req_reg.drain ? centre : s1_req_reg.gray;

    assign lap = gle_pkg::LAP_W'({centre, 2'b00}) - gle_pkg::LAP_W'(up)
               - gle_pkg::LAP_W'(down) - gle_pkg::LAP_W'(left) - gle_pkg::LAP_W'(right);

    // clamp to 0..255
    always_comb
    begin
        if (lap[gle_pkg::LAP_W-1])
        begin
            level = '0;
        end
        else if (lap[gle_pkg::LAP_W-2:gle_pkg::GRAY_W] != '0)
        begin
            level = '1;
        end
        else
        begin
            level = lap[gle_pkg::GRAY_W-1:0];
        end
    end

    assign wr_en    = s1_valid_reg && s1_req_reg.wr_en;
    assign wr_addr  = s1_req_reg.addr_a;
    assign wr_data  = gle_pkg::slot_merge(word_a, s1_req_reg.wr_slot, s1_req_reg.gray);
    assign s1_valid = s1_valid_reg;
    assign push     = s1_valid_reg && s1_req_reg.emit;

    assign push_data.edge_res   = (level > edge_threshold);
    assign push_data.frame_last = s1_req_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_en_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_en_reg   <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg    <= req;
            s1_addr_b_reg <= rd_addr_b;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_word_reg <= wr_data;
        end
        // centre of this column is the left neighbor of the next one
        if (push)
        begin
            left_reg <= centre;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gle_outq.sv @@
// three-entry result queue between the stencil stage and the output channel
// depends on gle_pkg
`default_nettype none

module gle_outq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire gle_pkg::result_t            push_data,
    input  wire logic                        pop,
    output logic                             not_empty,
    output gle_pkg::result_t                 head,
    output logic      [gle_pkg::QCNT_W-1:0]  count
);

    gle_pkg::result_t            entry_reg [gle_pkg::QUEUE_DEPTH];
    logic [gle_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [gle_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [gle_pkg::QCNT_W-1:0]  cnt_reg,    cnt_next;
    logic                        do_pop;

    assign not_empty = (cnt_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = cnt_reg;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == gle_pkg::QPTR_W'(gle_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == gle_pkg::QPTR_W'(gle_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gray_laplacian_edge_threshold.sv @@
// top level of the gray laplacian edge detector with threshold
// depends on gle_pkg, gle_ram, gle_front, gle_stencil and gle_outq
//
// usage:
//  - input channel (in_valid/in_ready): one request per pixel in raster order,
//    op selects pixel or drain; red/green/blue are ignored by a drain request
//  - output channel (out_valid/out_ready): one edge bit per pixel, frame_last on
//    the final pixel of the frame; results lag the input by one row, and once the
//    last row is in, one drain request per pixel flushes that row
//  - config port: cfg_wr_en with cfg_index/cfg_data writes frame_width,
//    frame_height or edge_threshold; write only while the block is idle
//  - a taken request is registered into the stencil stage, and its result into the result queue that drives the output
//  - throughput: one request per clock while the receiver keeps up; each request is one
//    read-modify-write of the line store word at its column (read port a, write
//    port) plus a read of the right neighbor (read port b)
//  - the line store holds three gray rows per column word; the left neighbor
//    comes from the previous column's read
//  - reset: counters cleared, registers back to 640x480 and threshold 128; the
//    line store is not cleared, rows are written before they are read
//  - receiver stall: a three-entry result queue takes what is in flight;
//    in_ready drops once queue plus stage are full
`default_nettype none

module gray_laplacian_edge_threshold (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input requests
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            op,
    input  wire logic [7:0]                      red,
    input  wire logic [7:0]                      green,
    input  wire logic [7:0]                      blue,
    // results
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 edge_res,
    output logic                                 frame_last,
    // configuration writes
    input  wire logic                            cfg_wr_en,
    input  wire logic [gle_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gle_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [gle_pkg::FW_W-1:0]  frame_width_reg;
    logic [gle_pkg::FH_W-1:0]  frame_height_reg;
    logic [gle_pkg::THR_W-1:0] edge_threshold_reg;

    logic                          accept;
    gle_pkg::s1_req_t              req;
    logic [gle_pkg::COL_W-1:0]     rd_addr_a;
    logic [gle_pkg::COL_W-1:0]     rd_addr_b;
    logic [gle_pkg::WORD_W-1:0]    rd_data_a;
    logic [gle_pkg::WORD_W-1:0]    rd_data_b;
    logic                          ram_wr_en;
    logic [gle_pkg::COL_W-1:0]     ram_wr_addr;
    logic [gle_pkg::WORD_W-1:0]    ram_wr_data;
    logic                          s1_valid;
    logic                          push;
    gle_pkg::result_t              push_data;
    gle_pkg::result_t              head;
    logic [gle_pkg::QCNT_W-1:0]    q_count;
    logic                          pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= gle_pkg::FW_RESET;
            frame_height_reg   <= gle_pkg::FH_RESET;
            edge_threshold_reg <= gle_pkg::THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            // indexes beyond the list are dropped
            case (cfg_index)
                gle_pkg::CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[gle_pkg::FW_W-1:0];
                gle_pkg::CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[gle_pkg::FH_W-1:0];
                gle_pkg::CFG_EDGE_THRESHOLD: edge_threshold_reg <= cfg_data[gle_pkg::THR_W-1:0];
                default:                     ;
            endcase
        end
    end

    // room for the stage in flight and everything queued
    assign in_ready = ((gle_pkg::QCNT_W + 1)'(q_count) + (gle_pkg::QCNT_W + 1)'(s1_valid))
                    < (gle_pkg::QCNT_W + 1)'(gle_pkg::QUEUE_DEPTH);
    assign accept   = in_valid && in_ready;

    gle_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (op),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .req          (req)
    );

    // line store: one word per column, one gray byte per row slot
    gle_ram #(
        .WIDTH (gle_pkg::WORD_W),
        .DEPTH (gle_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    gle_stencil u_stencil (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .req            (req),
        .rd_addr_b      (rd_addr_b),
        .ram_a          (rd_data_a),
        .ram_b          (rd_data_b),
        .edge_threshold (edge_threshold_reg),
        .wr_en          (ram_wr_en),
        .wr_addr        (ram_wr_addr),
        .wr_data        (ram_wr_data),
        .s1_valid       (s1_valid),
        .push           (push),
        .push_data      (push_data)
    );

    assign pop = out_valid && out_ready;

    gle_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (out_valid),
        .head      (head),
        .count     (q_count)
    );

    assign edge_res   = head.edge_res;
    assign frame_last = head.frame_last;

`ifndef SYNTHESIS
    // the queue never takes a result while full, unless one is popped in the same cycle
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (q_count != gle_pkg::QCNT_W'(gle_pkg::QUEUE_DEPTH)))
        else $error("result queue overflow");

    // line store is written only in the cycle after a request is taken
    a_write_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> $past(accept))
        else $error("line store write without a request");

    // a result enters the queue only from a live stage
    a_push_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (s1_valid && $past(in_valid && in_ready)))
        else $error("result pushed without a request in flight");
`endif

endmodule

`default_nettype wire
